// ===== src/dsmq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsmq_pkg
// Shared types and constants for the delay-sorted message queue.
// ----------------------------------------------------------------------------
package dsmq_pkg;

    // Default number of queue slots
    localparam int DSMQ_DEPTH = 16;

    // Field widths
    localparam int DELAY_W = 31;
    localparam int PROC_W  = 8;
    localparam int ENV_W   = 16;
    localparam int SEND_W  = 8;
    localparam int COUNT_W = 5;

    // Operation codes
    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_DONE = 1'b1
    } t_state;

    // One queued entry
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [PROC_W-1:0]  proc_id;
        logic [ENV_W-1:0]   envelope;
        logic [SEND_W-1:0]  sender;
    } t_entry;

    // Command from controller to datapath
    typedef struct packed {
        logic exec;
        t_op  op;
    } t_dp_cmd;

endpackage

// ===== src/dsmq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsmq_ctrl
// Controller: accepts one transaction, fires the datapath, strobes the result.
// ----------------------------------------------------------------------------
module dsmq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_op,
    output logic             busy,
    output logic             o_done,
    output dsmq_pkg::t_dp_cmd o_cmd
);
    import dsmq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        busy       = 1'b0;
        o_done     = 1'b0;
        o_cmd.exec = 1'b0;
        o_cmd.op   = t_op'(i_op);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                busy    = 1'b1;
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A result strobe always follows an accepted transaction
    a_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result strobe without accepted transaction");

    // An accepted transaction gives a strobe in the next cycle
    a_accept_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("accepted transaction gave no result");

    // No transaction is taken while a result is shown
    a_no_exec_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_cmd.exec)
        else $error("datapath fired while result strobe high");
`endif

endmodule

// ===== src/dsmq_datapath.sv =====
// ----------------------------------------------------------------------------
// dsmq_datapath
// Sorted slot chain: parallel compare of every slot, then insert or shift.
// ----------------------------------------------------------------------------
module dsmq_datapath #(
    parameter int QUEUE_DEPTH = dsmq_pkg::DSMQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsmq_pkg::t_dp_cmd             i_cmd,
    input  logic [dsmq_pkg::PROC_W-1:0]   i_proc_id,
    input  logic [dsmq_pkg::ENV_W-1:0]    i_envelope_handle,
    input  logic [dsmq_pkg::DELAY_W-1:0]  i_wait_delay,
    input  logic [dsmq_pkg::SEND_W-1:0]   i_sender,
    output logic [1:0]                    o_status,
    output logic [dsmq_pkg::PROC_W-1:0]   o_out_proc_id,
    output logic [dsmq_pkg::ENV_W-1:0]    o_out_envelope,
    output logic [dsmq_pkg::DELAY_W-1:0]  o_out_delay,
    output logic [dsmq_pkg::SEND_W-1:0]   o_out_sender,
    output logic [dsmq_pkg::COUNT_W-1:0]  o_entry_count
);
    import dsmq_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_slot [QUEUE_DEPTH];
    t_entry             n_slot [QUEUE_DEPTH];
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    t_status            r_status;
    t_status            n_status;
    t_entry             r_res;
    t_entry             n_res;
    logic [QUEUE_DEPTH-1:0] take;
    logic               full;
    logic               empty;
    logic [31:0]        fill_ext;
    t_entry             new_entry;

    assign full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign empty = (r_fill == '0);

    assign new_entry.delay    = i_wait_delay;
    assign new_entry.proc_id  = i_proc_id;
    assign new_entry.envelope = i_envelope_handle;
    assign new_entry.sender   = i_sender;

    // Per-slot test: slot lies at or after the insert point
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            take[i] = !((FILL_W'(i) < r_fill) && (r_slot[i].delay <= i_wait_delay));
        end
    end

    // Next slot contents, fill count and result
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slot[i] = r_slot[i];
        end
        n_fill   = r_fill;
        n_status = r_status;
        n_res    = r_res;
        if (i_cmd.exec) begin
            n_res    = '0;
            n_status = ST_OK;
            unique case (i_cmd.op)
                OP_ENQ: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        // slots past the insert point move down by one
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                            if (take[i]) begin
                                if (i == 0) begin
                                    n_slot[i] = new_entry;
                                end else if (take[i-1]) begin
                                    n_slot[i] = r_slot[i-1];
                                end else begin
                                    n_slot[i] = new_entry;
                                end
                            end
                        end
                        n_fill = r_fill + 1'b1;
                    end
                end
                OP_DEQ: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // head leaves, the rest move up by one
                        n_res = r_slot[0];
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            n_slot[i] = r_slot[i+1];
                        end
                        n_fill = r_fill - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Slot chain and result registers (payload, no reset)
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_slot[i] <= n_slot[i];
        end
        r_res <= n_res;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_status <= ST_OK;
        end else begin
            r_fill   <= n_fill;
            r_status <= n_status;
        end
    end

    // Result ports
    assign fill_ext       = 32'(r_fill);
    assign o_entry_count  = fill_ext[COUNT_W-1:0];
    assign o_status       = r_status;
    assign o_out_proc_id  = r_res.proc_id;
    assign o_out_envelope = r_res.envelope;
    assign o_out_delay    = r_res.delay;
    assign o_out_sender   = r_res.sender;

`ifndef ASSERT_OFF
    // Fill count never exceeds the slot count
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // A successful enqueue grows the queue by one
    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_cmd.op == OP_ENQ && !full)
        |=> (r_fill == $past(r_fill) + 1'b1) && (r_status == ST_OK))
        else $error("enqueue did not grow queue");

    // Dequeue from an empty queue reports empty and leaves it empty
    a_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_cmd.op == OP_DEQ && empty)
        |=> (r_status == ST_EMPTY) && (r_fill == '0))
        else $error("empty dequeue mishandled");

    // Enqueue into a full queue keeps the count
    a_enq_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && i_cmd.op == OP_ENQ && full)
        |=> (r_status == ST_FULL) && $stable(r_fill))
        else $error("full enqueue changed the queue");
`endif

endmodule

// ===== src/delay_sorted_message_queue.sv =====
// ----------------------------------------------------------------------------
// delay_sorted_message_queue
// Bounded queue of delayed-send entries kept in ascending delay order.
// ----------------------------------------------------------------------------
// Each transaction (enqueue or dequeue) is accepted when start is high and
// busy is low; every slot of the sorted register chain is compared against
// the new delay in parallel and the chain inserts or shifts on that same
// edge, and the result is shown in the following cycle with o_done high
// for exactly one cycle while busy is high. The receiver cannot
// hold a result off, so it must capture the ports whenever o_done is high.
// Entries with equal delay leave in arrival order; o_entry_count gives the
// number of held entries modulo 32.
module delay_sorted_message_queue #(
    parameter int QUEUE_DEPTH = dsmq_pkg::DSMQ_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic [dsmq_pkg::PROC_W-1:0]   i_proc_id,
    input  logic [dsmq_pkg::ENV_W-1:0]    i_envelope_handle,
    input  logic [dsmq_pkg::DELAY_W-1:0]  i_wait_delay,
    input  logic [dsmq_pkg::SEND_W-1:0]   i_sender,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic [dsmq_pkg::PROC_W-1:0]   o_out_proc_id,
    output logic [dsmq_pkg::ENV_W-1:0]    o_out_envelope,
    output logic [dsmq_pkg::DELAY_W-1:0]  o_out_delay,
    output logic [dsmq_pkg::SEND_W-1:0]   o_out_sender,
    output logic [dsmq_pkg::COUNT_W-1:0]  o_entry_count
);
    import dsmq_pkg::*;

    t_dp_cmd cmd;

    // Controller
    dsmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    // Sorted slot chain
    dsmq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_proc_id         (i_proc_id),
        .i_envelope_handle (i_envelope_handle),
        .i_wait_delay      (i_wait_delay),
        .i_sender          (i_sender),
        .o_status          (o_status),
        .o_out_proc_id     (o_out_proc_id),
        .o_out_envelope    (o_out_envelope),
        .o_out_delay       (o_out_delay),
        .o_out_sender      (o_out_sender),
        .o_entry_count     (o_entry_count)
    );

endmodule
